### hdl/psched_pkg.sv
// ----------------------------------------------------------------------------
// psched_pkg
// shared types, codes and sizes of the priority task scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package psched_pkg;

    // table geometry
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int USED_W     = $clog2(TASK_SLOTS + 1);
    localparam int OUT_SLOT_W = 4;

    // field widths
    localparam int CMD_W   = 3;
    localparam int PRIO_W  = 8;
    localparam int DELAY_W = 16;
    localparam int CNT_W   = 16;
    localparam int ERR_W   = 2;
    localparam int ISR_W   = 8;
    localparam int STAT_W  = 2;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [PRIO_W-1:0]  prio_t;
    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [STAT_W-1:0]  status_t;

    // task status
    localparam status_t ST_READY   = 2'd0;
    localparam status_t ST_RUNNING = 2'd1;
    localparam status_t ST_BLOCKED = 2'd2;

    // commands
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELAY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ISR_IN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ISR_OUT = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_RUN    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd3;

    // write request into the slot table
    typedef struct packed {
        logic    en;
        slot_t   addr;
        logic    set_prio;
        prio_t   prio;
        logic    set_status;
        status_t status;
        logic    set_delay;
        delay_t  delay;
    } tbl_wr_t;

    // read data out of the slot table
    typedef struct packed {
        prio_t   prio;
        status_t status;
        delay_t  delay;
    } tbl_rd_t;

endpackage

`default_nettype wire

### hdl/psched_table.sv
// ----------------------------------------------------------------------------
// psched_table
// per-slot priority, status and delay storage, one read and one write port
// ----------------------------------------------------------------------------
`default_nettype none

module psched_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire psched_pkg::prio_t idle_priority,
    input  wire psched_pkg::slot_t rd_addr,
    output psched_pkg::tbl_rd_t    rd,
    input  wire psched_pkg::tbl_wr_t wr
);
    import psched_pkg::*;

    prio_t   prio_reg   [TASK_SLOTS];
    status_t status_reg [TASK_SLOTS];
    delay_t  delay_reg  [TASK_SLOTS];

    // priorities are written by create only, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.set_prio)
        begin
            prio_reg[wr.addr] <= wr.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                status_reg[i] <= ST_READY;
                delay_reg[i]  <= '0;
            end
        end
        else if (wr.en)
        begin
            if (wr.set_status)
            begin
                status_reg[wr.addr] <= wr.status;
            end
            if (wr.set_delay)
            begin
                delay_reg[wr.addr] <= wr.delay;
            end
        end
    end

    // slot zero always follows the idle priority register
    always_comb
    begin
        rd.prio   = (rd_addr == '0) ? idle_priority : prio_reg[rd_addr];
        rd.status = status_reg[rd_addr];
        rd.delay  = delay_reg[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/psched_ctrl.sv
// ----------------------------------------------------------------------------
// psched_ctrl
// command sequencer with one shared subtract/compare unit over the slot table
// ----------------------------------------------------------------------------
`default_nettype none

module psched_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [psched_pkg::CMD_W-1:0]  command,
    input  wire psched_pkg::prio_t             task_priority,
    input  wire psched_pkg::delay_t            delay_ticks,
    output logic                               busy,
    output logic                               done,
    output logic [psched_pkg::OUT_SLOT_W-1:0]  running_slot,
    output logic                               switched,
    output logic [psched_pkg::ERR_W-1:0]       error_code,
    output logic [psched_pkg::CNT_W-1:0]       switch_count,
    output logic [psched_pkg::CNT_W-1:0]       tick_count,
    output psched_pkg::slot_t                  rd_addr,
    input  wire psched_pkg::tbl_rd_t           rd,
    output psched_pkg::tbl_wr_t                wr
);
    import psched_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_PICK    = 3'd3;
    localparam logic [2:0] S_DEMOTE  = 3'd4;
    localparam logic [2:0] S_PROMOTE = 3'd5;
    localparam logic [2:0] S_TICK    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    prio_t            prio_reg, prio_next;
    delay_t           ticks_reg, ticks_next;
    logic [USED_W-1:0] used_reg, used_next;
    slot_t            cur_reg, cur_next;
    logic             started_reg, started_next;
    logic             first_reg, first_next;
    logic [ISR_W-1:0] isr_reg, isr_next;
    logic [CNT_W-1:0] disp_reg, disp_next;
    logic [CNT_W-1:0] ticks_total_reg, ticks_total_next;
    slot_t            idx_reg, idx_next;
    slot_t            best_reg, best_next;
    prio_t            best_prio_reg, best_prio_next;
    logic             best_run_reg, best_run_next;
    logic             found_reg, found_next;
    logic             chk_reg, chk_next;
    logic             sw_reg, sw_next;
    logic [ERR_W-1:0] err_reg, err_next;

    // shared subtract/compare unit
    delay_t           unit_a, unit_b;
    logic [DELAY_W:0] unit_diff;
    logic             unit_lt;
    logic             last_idx;

    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_lt   = unit_diff[DELAY_W];
    assign last_idx  = ((USED_W'(idx_reg) + USED_W'(1)) == used_reg);

    always_comb
    begin
        if (state_reg == S_TICK)
        begin
            unit_a = rd.delay;
            unit_b = DELAY_W'(1);
        end
        else
        begin
            unit_a = DELAY_W'(rd.prio);
            unit_b = DELAY_W'(best_prio_reg);
        end
    end

    assign rd_addr = (state_reg == S_DEMOTE) ? cur_reg : idx_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        prio_next        = prio_reg;
        ticks_next       = ticks_reg;
        used_next        = used_reg;
        cur_next         = cur_reg;
        started_next     = started_reg;
        first_next       = first_reg;
        isr_next         = isr_reg;
        disp_next        = disp_reg;
        ticks_total_next = ticks_total_reg;
        idx_next         = idx_reg;
        best_next        = best_reg;
        best_prio_next   = best_prio_reg;
        best_run_next    = best_run_reg;
        found_next       = found_reg;
        chk_next         = chk_reg;
        sw_next          = sw_reg;
        err_next         = err_reg;
        wr               = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    prio_next  = task_priority;
                    ticks_next = delay_ticks;
                    sw_next    = 1'b0;
                    err_next   = ERR_OK;
                    idx_next   = '0;
                    found_next = 1'b0;
                    chk_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        if (used_reg >= USED_W'(TASK_SLOTS))
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            wr.en         = 1'b1;
                            wr.addr       = SLOT_W'(used_reg);
                            wr.set_prio   = 1'b1;
                            wr.prio       = prio_reg;
                            wr.set_status = 1'b1;
                            wr.status     = ST_READY;
                            wr.set_delay  = 1'b1;
                            wr.delay      = '0;
                            used_next     = used_reg + USED_W'(1);
                            if (started_reg)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    end
                    CMD_START:
                    begin
                        chk_next   = !started_reg;
                        state_next = S_SCAN;
                    end
                    CMD_DELAY:
                    begin
                        if (!started_reg)
                        begin
                            err_next = ERR_NO_RUN;
                        end
                        else if (ticks_reg != '0 && cur_reg != '0)
                        begin
                            wr.en         = 1'b1;
                            wr.addr       = cur_reg;
                            wr.set_status = 1'b1;
                            wr.status     = ST_BLOCKED;
                            wr.set_delay  = 1'b1;
                            wr.delay      = ticks_reg;
                            state_next    = S_SCAN;
                        end
                    end
                    CMD_TICK:
                    begin
                        ticks_total_next = ticks_total_reg + CNT_W'(1);
                        state_next       = S_TICK;
                    end
                    CMD_ISR_IN:
                    begin
                        if (isr_reg != '1)
                        begin
                            isr_next = isr_reg + ISR_W'(1);
                        end
                    end
                    CMD_ISR_OUT:
                    begin
                        if (isr_reg == '0)
                        begin
                            err_next = ERR_UNDERFLOW;
                        end
                        else
                        begin
                            isr_next = isr_reg - ISR_W'(1);
                            if (isr_reg == ISR_W'(1) && started_reg)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // lowest number wins, ties keep the earlier slot
                if (rd.status != ST_BLOCKED && (!found_reg || unit_lt))
                begin
                    best_next      = idx_reg;
                    best_prio_next = rd.prio;
                    best_run_next  = (rd.status == ST_RUNNING);
                    found_next     = 1'b1;
                end
                if (last_idx)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_PICK:
            begin
                if (chk_reg && best_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (chk_reg)
                    begin
                        started_next = 1'b1;
                    end
                    if (best_run_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (!first_reg)
                    begin
                        state_next = S_DEMOTE;
                    end
                    else
                    begin
                        state_next = S_PROMOTE;
                    end
                end
            end

            S_DEMOTE:
            begin
                if (rd.status == ST_RUNNING)
                begin
                    wr.en         = 1'b1;
                    wr.addr       = cur_reg;
                    wr.set_status = 1'b1;
                    wr.status     = ST_READY;
                end
                state_next = S_PROMOTE;
            end

            S_PROMOTE:
            begin
                wr.en         = 1'b1;
                wr.addr       = best_reg;
                wr.set_status = 1'b1;
                wr.status     = ST_RUNNING;
                cur_next      = best_reg;
                disp_next     = disp_reg + CNT_W'(1);
                first_next    = 1'b0;
                sw_next       = 1'b1;
                state_next    = S_DONE;
            end

            S_TICK:
            begin
                if (rd.delay != '0)
                begin
                    wr.en        = 1'b1;
                    wr.addr      = idx_reg;
                    wr.set_delay = 1'b1;
                    wr.delay     = unit_diff[DELAY_W-1:0];
                    if (unit_diff[DELAY_W-1:0] == '0)
                    begin
                        wr.set_status = 1'b1;
                        wr.status     = ST_READY;
                    end
                end
                if (last_idx)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= USED_W'(1);
            cur_reg         <= '0;
            started_reg     <= 1'b0;
            first_reg       <= 1'b1;
            isr_reg         <= '0;
            disp_reg        <= '0;
            ticks_total_reg <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            chk_reg         <= 1'b0;
            sw_reg          <= 1'b0;
            err_reg         <= ERR_OK;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            cur_reg         <= cur_next;
            started_reg     <= started_next;
            first_reg       <= first_next;
            isr_reg         <= isr_next;
            disp_reg        <= disp_next;
            ticks_total_reg <= ticks_total_next;
            idx_reg         <= idx_next;
            found_reg       <= found_next;
            chk_reg         <= chk_next;
            sw_reg          <= sw_next;
            err_reg         <= err_next;
        end
    end

    // request payload and scan scratch
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        prio_reg      <= prio_next;
        ticks_reg     <= ticks_next;
        best_reg      <= best_next;
        best_prio_reg <= best_prio_next;
        best_run_reg  <= best_run_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign running_slot = OUT_SLOT_W'(cur_reg);
    assign switched     = sw_reg;
    assign error_code   = err_reg;
    assign switch_count = disp_reg;
    assign tick_count   = ticks_total_reg;

endmodule

`default_nettype wire

### hdl/priority_task_scheduler_with_delays.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays
// hardware task scheduler: slot table, sequencer and idle priority register
// ----------------------------------------------------------------------------
//
// channel      | direction | handshake         | payload
// -------------+-----------+-------------------+-------------------------------
// request      | in        | start & !busy     | command, task_priority,
//              |           |                   | delay_ticks
// result       | out       | done (one cycle)  | running_slot, switched,
//              |           |                   | error_code, switch_count,
//              |           |                   | tick_count
// idle prio    | in        | cfg_we            | cfg_data
//
// a request with no table pass (most isr requests, errors) goes from exec to
// done; a tick first walks the slots in use, and one that runs the scheduler
// scans them, picks, then may demote and promote before done
// a pass is paced by the single table read port and shared compare unit,
// which visit one slot per cycle
// the result holds from done until the next request; the receiver cannot stall
// reset is asynchronous: slot zero ready as idle, all delays cleared
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_with_delays (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [psched_pkg::CMD_W-1:0]  command,
    input  wire psched_pkg::prio_t             task_priority,
    input  wire psched_pkg::delay_t            delay_ticks,
    input  wire logic                          cfg_we,
    input  wire psched_pkg::prio_t             cfg_data,
    output logic                               done,
    output logic [psched_pkg::OUT_SLOT_W-1:0]  running_slot,
    output logic                               switched,
    output logic [psched_pkg::ERR_W-1:0]       error_code,
    output logic [psched_pkg::CNT_W-1:0]       switch_count,
    output logic [psched_pkg::CNT_W-1:0]       tick_count
);
    import psched_pkg::*;

    prio_t   idle_prio_reg;
    slot_t   rd_addr;
    tbl_rd_t rd;
    tbl_wr_t wr;

    // idle task priority, read back through slot zero of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_prio_reg <= '1;
        end
        else if (cfg_we)
        begin
            idle_prio_reg <= cfg_data;
        end
    end

    // slot storage
    psched_table u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .idle_priority (idle_prio_reg),
        .rd_addr       (rd_addr),
        .rd            (rd),
        .wr            (wr)
    );

    // command sequencer, scans slots one per cycle
    psched_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .command       (command),
        .task_priority (task_priority),
        .delay_ticks   (delay_ticks),
        .busy          (busy),
        .done          (done),
        .running_slot  (running_slot),
        .switched      (switched),
        .error_code    (error_code),
        .switch_count  (switch_count),
        .tick_count    (tick_count),
        .rd_addr       (rd_addr),
        .rd            (rd),
        .wr            (wr)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the priority task scheduler: a queue-fed request
// driver, a result monitor and a cycle-free behavioural predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import psched_pkg::*;

    // one request as offered to the scheduler
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        prio_t            prio;
        delay_t           ticks;
    } request_t;

    // one result as reported on the done strobe
    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot;
        logic                  switched;
        logic [ERR_W-1:0]      err;
        logic [CNT_W-1:0]      switches;
        logic [CNT_W-1:0]      ticks;
    } outcome_t;

    // the scheduler's port signals, the inputs all known from time zero
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  start         = 1'b0;
    logic [CMD_W-1:0]      command       = CMD_TICK;
    prio_t                 task_priority = '0;
    delay_t                delay_ticks   = '0;
    logic                  cfg_we        = 1'b0;
    prio_t                 cfg_data      = '0;
    logic                  busy;
    logic                  done;
    logic [OUT_SLOT_W-1:0] running_slot;
    logic                  switched;
    logic [ERR_W-1:0]      error_code;
    logic [CNT_W-1:0]      switch_count;
    logic [CNT_W-1:0]      tick_count;

    // requests waiting to be offered, and outcomes waiting to be reported
    request_t request_backlog[$];
    outcome_t expected_outcomes[$];
    request_t on_offer;

    // run bookkeeping
    bit          steady = 1'b0;     // no gaps between requests while set
    int unsigned mismatches;
    int unsigned requests_taken;
    int unsigned outcomes_checked;
    int unsigned idle_settings;

    // predicted scheduler state
    prio_t            slot_prio[TASK_SLOTS];
    status_t          slot_state[TASK_SLOTS];
    delay_t           slot_wait[TASK_SLOTS];
    int               slots_in_use;
    int               active_slot;
    bit               sched_on;
    bit               first_pending;
    logic [ISR_W-1:0] isr_level;
    logic [CNT_W-1:0] dispatch_total;
    logic [CNT_W-1:0] tick_total;

    priority_task_scheduler_with_delays DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .task_priority (task_priority),
        .delay_ticks   (delay_ticks),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .running_slot  (running_slot),
        .switched      (switched),
        .error_code    (error_code),
        .switch_count  (switch_count),
        .tick_count    (tick_count)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // state straight after reset: only the idle task exists, at priority 255
    function automatic void clear_scheduler_state();
        int i;
        for (i = 0; i < TASK_SLOTS; i++)
        begin
            slot_prio[i]  = '0;
            slot_state[i] = ST_READY;
            slot_wait[i]  = '0;
        end
        slot_prio[0]   = 8'hFF;
        slots_in_use   = 1;
        active_slot    = 0;
        sched_on       = 1'b0;
        first_pending  = 1'b1;
        isr_level      = '0;
        dispatch_total = '0;
        tick_total     = '0;
    endfunction

    // most urgent slot that is not blocked; ties go to the lower index
    function automatic int pick_ready_slot();
        int best_slot;
        int i;
        bit found;
        best_slot = 0;
        found     = 1'b0;
        for (i = 0; i < slots_in_use && i < TASK_SLOTS; i++)
        begin
            if (slot_state[i] != ST_BLOCKED &&
                (!found || slot_prio[i] < slot_prio[best_slot]))
            begin
                best_slot = i;
                found     = 1'b1;
            end
        end
        return best_slot;
    endfunction

    // run the scheduler; returns whether a different task got the cpu
    function automatic bit dispatch_task();
        int chosen;
        chosen = pick_ready_slot();
        if (slot_state[chosen] == ST_RUNNING)
            return 1'b0;
        // the old task steps down only once a first dispatch has happened
        if (!first_pending && slot_state[active_slot] == ST_RUNNING)
            slot_state[active_slot] = ST_READY;
        first_pending      = 1'b0;
        slot_state[chosen] = ST_RUNNING;
        active_slot        = chosen;
        dispatch_total     = dispatch_total + 1'b1;
        return 1'b1;
    endfunction

    // apply one request to the predicted state and form its outcome
    function automatic outcome_t schedule_request(request_t req);
        outcome_t res;
        bit sw;
        logic [ERR_W-1:0] err;
        int i;
        sw  = 1'b0;
        err = ERR_OK;
        case (req.cmd)
            CMD_CREATE:
            begin
                if (slots_in_use >= TASK_SLOTS)
                    err = ERR_FULL;
                else
                begin
                    slot_prio[slots_in_use]  = req.prio;
                    slot_state[slots_in_use] = ST_READY;
                    slot_wait[slots_in_use]  = '0;
                    slots_in_use++;
                    if (sched_on)
                        sw = dispatch_task();
                end
            end
            CMD_START:
            begin
                // before the first start, only a task more urgent than idle
                // switches scheduling on
                if (sched_on)
                    sw = dispatch_task();
                else if (pick_ready_slot() != 0)
                begin
                    sched_on = 1'b1;
                    sw       = dispatch_task();
                end
            end
            CMD_DELAY:
            begin
                // zero ticks, or the idle task running, leave things alone
                if (!sched_on)
                    err = ERR_NO_RUN;
                else if (req.ticks != 0 && active_slot != 0)
                begin
                    slot_wait[active_slot]  = req.ticks;
                    slot_state[active_slot] = ST_BLOCKED;
                    sw = dispatch_task();
                end
            end
            CMD_TICK:
            begin
                // a tick wakes tasks but never reschedules
                tick_total = tick_total + 1'b1;
                for (i = 0; i < slots_in_use && i < TASK_SLOTS; i++)
                begin
                    if (slot_wait[i] != 0)
                    begin
                        slot_wait[i] = slot_wait[i] - 1'b1;
                        if (slot_wait[i] == 0)
                            slot_state[i] = ST_READY;
                    end
                end
            end
            CMD_ISR_IN:
            begin
                if (isr_level != {ISR_W{1'b1}})
                    isr_level = isr_level + 1'b1;
            end
            CMD_ISR_OUT:
            begin
                if (isr_level == 0)
                    err = ERR_UNDERFLOW;
                else
                begin
                    isr_level = isr_level - 1'b1;
                    if (isr_level == 0 && sched_on)
                        sw = dispatch_task();
                end
            end
            default:
            begin
                // unused command codes are ignored
            end
        endcase
        res.slot     = active_slot[OUT_SLOT_W-1:0];
        res.switched = sw;
        res.err      = err;
        res.switches = dispatch_total;
        res.ticks    = tick_total;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers the backlog one request at a time, holding each until
    // the scheduler takes it; gaps roll in at random unless steady is set
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_outcomes.push_back(schedule_request(on_offer));
                requests_taken++;
            end
            if (start && busy)
            begin
                // still waiting for the scheduler, keep the request steady
            end
            else if (request_backlog.size() != 0 &&
                     (steady || $urandom_range(99) >= 23))
            begin
                on_offer      = request_backlog.pop_front();
                start         <= 1'b1;
                command       <= on_offer.cmd;
                task_priority <= on_offer.prio;
                delay_ticks   <= on_offer.ticks;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every done strobe is matched against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result reported with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                outcomes_checked++;
                if (running_slot !== want.slot)
                begin
                    $error("running_slot: expected %0d, got %0d", want.slot, running_slot);
                    mismatches++;
                end
                if (switched !== want.switched)
                begin
                    $error("switched: expected %0d, got %0d", want.switched, switched);
                    mismatches++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err, error_code);
                    mismatches++;
                end
                if (switch_count !== want.switches)
                begin
                    $error("switch_count: expected %0d, got %0d",
                           want.switches, switch_count);
                    mismatches++;
                end
                if (tick_count !== want.ticks)
                begin
                    $error("tick_count: expected %0d, got %0d", want.ticks, tick_count);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_request(input logic [CMD_W-1:0] cmd, input prio_t prio,
                               input delay_t ticks);
        request_t req;
        req.cmd   = cmd;
        req.prio  = prio;
        req.ticks = ticks;
        request_backlog.push_back(req);
    endtask

    // random request mix: plenty of ticks and delays to keep tasks moving
    // between blocked and ready, fewer creates since the table fills early
    task automatic add_random_requests(input int count);
        int n;
        int roll;
        logic [CMD_W-1:0] cmd;
        prio_t prio;
        delay_t ticks;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                cmd = CMD_CREATE;
            else if (roll < 18)
                cmd = CMD_START;
            else if (roll < 42)
                cmd = CMD_DELAY;
            else if (roll < 72)
                cmd = CMD_TICK;
            else if (roll < 85)
                cmd = CMD_ISR_IN;
            else if (roll < 98)
                cmd = CMD_ISR_OUT;
            else
                cmd = CMD_W'($urandom_range(7, 6));

            roll = $urandom_range(99);
            if (roll < 10)
                prio = '0;
            else if (roll < 20)
                prio = 8'hFF;
            else
                prio = prio_t'($urandom);

            // mostly short delays; a rare full-range one parks a task much longer
            roll = $urandom_range(99);
            if (roll < 10)
                ticks = '0;
            else if (roll < 75)
                ticks = delay_t'($urandom_range(6, 1));
            else if (roll < 98)
                ticks = delay_t'($urandom_range(40, 7));
            else
                ticks = delay_t'($urandom);

            add_request(cmd, prio, ticks);
        end
    endtask

    // wait for the backlog and all predictions to drain, then let the last
    // request's table pass finish
    task automatic wait_until_quiet();
        @(negedge clk);
        while (request_backlog.size() != 0 || start || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (TASK_SLOTS + 10) @(posedge clk);
    endtask

    // idle priority register write, mirrored into slot zero of the predictor
    task automatic set_idle_priority(input prio_t value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        slot_prio[0] = value;
        idle_settings++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        clear_scheduler_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_idle_priority(8'hFF);

        // directed: behaviour before scheduling starts
        add_request(CMD_ISR_OUT, 8'h00, 16'h0000);     // underflow at depth zero
        add_request(CMD_DELAY,   8'h00, 16'h0005);     // nothing running yet
        add_request(CMD_START,   8'h00, 16'h0000);     // only idle, stays off
        add_request(CMD_ISR_IN,  8'h00, 16'h0000);
        add_request(CMD_ISR_OUT, 8'h00, 16'h0000);     // falls without rescheduling
        add_request(CMD_TICK,    8'h00, 16'h0000);
        add_request(3'd6,        8'hA5, 16'h5A5A);     // unused codes are ignored
        add_request(3'd7,        8'h5A, 16'hA5A5);
        add_request(CMD_CREATE,  8'hFF, 16'h0000);     // ties idle, idle still wins
        add_request(CMD_START,   8'h00, 16'h0000);
        add_request(CMD_CREATE,  8'h00, 16'h0000);
        add_request(CMD_START,   8'h00, 16'h0000);     // first dispatch
        // directed: running system
        add_request(CMD_CREATE,  8'h00, 16'h0000);     // tie keeps the earlier slot
        add_request(CMD_DELAY,   8'h00, 16'h0000);     // zero delay
        add_request(CMD_DELAY,   8'h00, 16'h0001);
        add_request(CMD_TICK,    8'h00, 16'h0000);     // wakes, does not preempt
        add_request(CMD_START,   8'h00, 16'h0000);     // start again reschedules
        add_request(CMD_ISR_IN,  8'h00, 16'h0000);
        add_request(CMD_ISR_IN,  8'h00, 16'h0000);
        add_request(CMD_ISR_OUT, 8'h00, 16'h0000);
        add_request(CMD_ISR_OUT, 8'h00, 16'h0000);     // outermost exit reschedules
        add_request(CMD_DELAY,   8'h00, 16'hFFFF);
        add_request(CMD_DELAY,   8'h00, 16'h0003);     // falls back to the idle task
        add_request(CMD_DELAY,   8'h00, 16'h0002);     // idle cannot be delayed
        wait_until_quiet();

        // random phases over several idle priorities, extremes included
        set_idle_priority(8'h00);
        add_random_requests(225);
        wait_until_quiet();

        steady = 1'b1;
        set_idle_priority(prio_t'($urandom_range(254, 1)));
        add_random_requests(225);
        wait_until_quiet();
        steady = 1'b0;

        set_idle_priority(8'hFF);
        add_random_requests(225);
        wait_until_quiet();

        set_idle_priority(prio_t'($urandom_range(254, 1)));
        add_random_requests(225);
        wait_until_quiet();

        // isr nesting up past its ceiling, then back down past zero
        for (n = 0; n < 258; n++)
            add_request(CMD_ISR_IN, prio_t'($urandom), delay_t'($urandom));
        for (n = 0; n < 257; n++)
            add_request(CMD_ISR_OUT, prio_t'($urandom), delay_t'($urandom));
        wait_until_quiet();

        $display("summary: %0d requests checked against %0d results, %0d idle settings",
                 requests_taken, outcomes_checked, idle_settings);
        $display("summary: table filled, tasks delayed and woken, isr nesting saturated");
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
hdl/psched_pkg.sv
hdl/psched_table.sv
hdl/psched_ctrl.sv
hdl/priority_task_scheduler_with_delays.sv
bench/testbench.sv
